// File: hdl/hcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcc_pkg: shared types and round functions for HChaCha20 subkey derivation
// Defines the transfer payloads, the 16-word ChaCha state and the column and
// diagonal round logic used by every pipeline stage.
// ----------------------------------------------------------------------------
package hcc_pkg;

    localparam int ROUND_COUNT = 20;
    localparam int WORD_W      = 32;
    localparam int STATE_WORDS = 16;

    localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

    localparam int ROT_A = 16;
    localparam int ROT_B = 12;
    localparam int ROT_C = 8;
    localparam int ROT_D = 7;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [STATE_WORDS-1:0][WORD_W-1:0] state_t;
    typedef logic [3:0][WORD_W-1:0] quad_t;

    typedef struct packed {
        logic [63:0] key_w0;
        logic [63:0] key_w1;
        logic [63:0] key_w2;
        logic [63:0] key_w3;
        logic [63:0] nonce_lo;
        logic [63:0] nonce_hi;
    } in_t;

    typedef struct packed {
        logic [63:0] subkey_w0;
        logic [63:0] subkey_w1;
        logic [63:0] subkey_w2;
        logic [63:0] subkey_w3;
    } out_t;

    function automatic word_t rotl(word_t v, int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    // Element 0..3 of the result are a, b, c, d.
    function automatic quad_t quarter_round(word_t a_in, word_t b_in,
                                            word_t c_in, word_t d_in);
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        quad_t q;
        a = a_in;
        b = b_in;
        c = c_in;
        d = d_in;
        a = a + b; d = rotl(d ^ a, ROT_A);
        c = c + d; b = rotl(b ^ c, ROT_B);
        a = a + b; d = rotl(d ^ a, ROT_C);
        c = c + d; b = rotl(b ^ c, ROT_D);
        q[0] = a;
        q[1] = b;
        q[2] = c;
        q[3] = d;
        return q;
    endfunction

    function automatic state_t column_round(state_t s);
        state_t t;
        quad_t  q;
        t = s;
        for (int i = 0; i < 4; i++) begin
            q = quarter_round(s[i], s[4 + i], s[8 + i], s[12 + i]);
            t[i]      = q[0];
            t[4 + i]  = q[1];
            t[8 + i]  = q[2];
            t[12 + i] = q[3];
        end
        return t;
    endfunction

    function automatic state_t diagonal_round(state_t s);
        state_t t;
        quad_t  q;
        t = s;
        for (int i = 0; i < 4; i++) begin
            q = quarter_round(s[i], s[4 + ((i + 1) % 4)],
                              s[8 + ((i + 2) % 4)], s[12 + ((i + 3) % 4)]);
            t[i]                  = q[0];
            t[4 + ((i + 1) % 4)]  = q[1];
            t[8 + ((i + 2) % 4)]  = q[2];
            t[12 + ((i + 3) % 4)] = q[3];
        end
        return t;
    endfunction

endpackage

// File: hdl/hchacha20_subkey_derive_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hchacha20_subkey_derive_unit: pipelined HChaCha20 subkey derivation
// Derives a 256-bit subkey from a 256-bit key and a 128-bit input.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one key and 128-bit input per transfer;
//   m_valid/m_ready/m_data carry the matching subkey, in order.
//   Each ChaCha round is one register stage, so the chain is ROUND_COUNT
//   stages deep (20 by default). Each item passes through every stage
//   register in order before m_valid rises for it. One transfer is accepted
//   per cycle while the output side takes results; the rate is set by the
//   round stage, which holds one state per cycle.
//   The last stage register is the output register. When the receiver stalls
//   the full stages hold their data; empty stages ahead of the stall still
//   fill, so s_ready drops only once every stage holds an item.
//   Reset clears all stage valid bits; no item survives reset.
// ----------------------------------------------------------------------------
module hchacha20_subkey_derive_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  hcc_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output hcc_pkg::out_t m_data
);
    import hcc_pkg::*;

    logic [ROUND_COUNT:0] stage_valid;
    logic [ROUND_COUNT:0] stage_ready;
    state_t               stage_state [ROUND_COUNT+1];
    state_t               final_state;

    // build the initial state from sigma, key and input words (word 0 lowest)
    assign stage_state[0] = {s_data.nonce_hi, s_data.nonce_lo,
                             s_data.key_w3, s_data.key_w2,
                             s_data.key_w1, s_data.key_w0,
                             SIGMA_3, SIGMA_2, SIGMA_1, SIGMA_0};

    assign stage_valid[0]           = s_valid;
    assign s_ready                  = stage_ready[0];
    assign stage_ready[ROUND_COUNT] = m_ready;

    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        // even rounds work on columns, odd rounds on diagonals
        hcc_round_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .diag      (1'(g % 2)),
            .in_valid  (stage_valid[g]),
            .in_ready  (stage_ready[g]),
            .in_state  (stage_state[g]),
            .out_valid (stage_valid[g+1]),
            .out_ready (stage_ready[g+1]),
            .out_state (stage_state[g+1])
        );
    end

    assign final_state = stage_state[ROUND_COUNT];
    assign m_valid     = stage_valid[ROUND_COUNT];

    assign m_data.subkey_w0 = {final_state[1],  final_state[0]};
    assign m_data.subkey_w1 = {final_state[3],  final_state[2]};
    assign m_data.subkey_w2 = {final_state[13], final_state[12]};
    assign m_data.subkey_w3 = {final_state[15], final_state[14]};

endmodule

// File: hdl/hcc_round_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcc_round_stage: one registered ChaCha round
// Applies a column or diagonal round to the incoming state and holds the
// result with its valid bit. Accepts a new state whenever empty or draining.
// ----------------------------------------------------------------------------
module hcc_round_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            diag,
    input  logic            in_valid,
    output logic            in_ready,
    input  hcc_pkg::state_t in_state,
    output logic            out_valid,
    input  logic            out_ready,
    output hcc_pkg::state_t out_state
);
    import hcc_pkg::*;

    logic   valid_reg;
    state_t state_reg;
    state_t state_next;

    assign state_next = diag ? diagonal_round(in_state) : column_round(in_state);
    assign in_ready   = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // hold the payload while stalled
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            state_reg <= state_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule
